// ===== rtl/att_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package att_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DUR_W     = 24;
  localparam int DVD_W     = 8 + 32 + FRAC_BITS;
  localparam int P_W       = DVD_W + 1;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int TERM_W    = 41;
  localparam int SUM_W     = 50;

  localparam logic [P_W-1:0]    ONE      = P_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0]    FMASK    = ONE - P_W'(1);
  localparam logic [TERM_W-1:0] TERM_LIM = TERM_W'(1) << 40;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_LOAD   = 2'd3;

  localparam logic [1:0] KIND_ADD_ACK = 2'd0;
  localparam logic [1:0] KIND_REM_ACK = 2'd1;
  localparam logic [1:0] KIND_FRAME   = 2'd2;
  localparam logic [1:0] KIND_EOT     = 2'd3;

  localparam logic [2:0] TY_BOUNCE     = 3'd2;
  localparam logic [2:0] TY_INFINITE   = 3'd3;
  localparam logic [2:0] TY_INF_BOUNCE = 3'd4;
  localparam logic [2:0] TY_TIMER      = 3'd5;
  localparam logic [2:0] TY_INF_TIMER  = 3'd6;
  localparam logic [2:0] TY_PARAM      = 3'd7;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [31:0]       anim_id;
    logic signed [31:0] start_val;
    logic signed [31:0] end_val;
    logic [23:0]       duration_ms;
    logic [7:0]        cycle_count;
    logic [2:0]        anim_type;
    logic [3:0]        point_index;
    logic signed [31:0] point_value;
    logic [4:0]        point_count;
    logic [31:0]       now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       result_id;
    logic signed [31:0] frame_value;
    logic              complete;
    logic              found;
    logic              last;
  } out_word_t;

  function automatic logic [32:0] mag32(input logic [31:0] v);
    logic [32:0] w;
    w = {v[31], v};
    return v[31] ? (33'd0 - w) : w;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (33'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/att_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module att_mul
  import att_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/att_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module att_div
  import att_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DUR_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DUR_W-1:0] rem_r;
  logic [DUR_W-1:0] dsr_r;
  logic [DVD_W-1:0] quo_r;
  logic [DUR_W:0]   sh;
  logic [DUR_W:0]   diff;
  logic             ge;
  logic [DUR_W-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_r, quo_r[DVD_W-1]};
    diff    = sh - {1'b0, dsr_r};
    ge      = sh >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[DUR_W-1:0] : sh[DUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/animation_tween_table.sv =====
// channel | dir | handshake          | word
// in_     | in  | in_valid/in_stall   | in_word_t: command, ids, values, time
// out_    | out | out_valid/out_stall | out_word_t: acks, frames, end of tick
// add copies its staged points into the slot before its ack; add and remove acks wait for a free output
// tick: empty slots are skipped, a running slot's progress comes from the 56-step shared
// divider, values are blended on the single shared multiplier, frames wait for a free output
// and an end of tick word closes the scan
// reset clears slot valid bits and the output valid flag and sets next id to 1; no clearing pass
// in_stall is low only when idle; an idle block takes a word while a result waits
module animation_tween_table
  import att_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int MAX_POINTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int PIW   = $clog2(MAX_POINTS);
  localparam int NPW   = $clog2(MAX_POINTS + 1);
  localparam int DEPTH = SLOTS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_COPY, S_SCAN, S_CE_MUL, S_DIV_GO, S_DIV_WAIT, S_SHAPE,
    S_KF_LAST, S_KF_DATA, S_K_MUL, S_K_IDX, S_K_RA, S_K_RB, S_K_MA, S_K_MB,
    S_K_SUM, S_BL0, S_BL1, S_BL2, S_BL3, S_OUT
  } state_t;

  state_t state_r;

  logic [SLOTS-1:0]        valid_r;
  logic [31:0]             slot_id_r    [SLOTS];
  logic [31:0]             slot_time_r  [SLOTS];
  logic signed [31:0]      slot_sv_r    [SLOTS];
  logic [32:0]             slot_delta_r [SLOTS];
  logic [DUR_W-1:0]        slot_dur_r   [SLOTS];
  logic [7:0]              slot_cyc_r   [SLOTS];
  logic [2:0]              slot_ty_r    [SLOTS];
  logic [NPW-1:0]          slot_np_r    [SLOTS];
  logic signed [31:0]      staged_r     [MAX_POINTS];
  logic [31:0]             kf_ram_r     [DEPTH];
  logic [31:0]             rd_data_r;
  logic [31:0]             next_id_r;

  logic [31:0]             now_r;
  logic [CW-1:0]           s_r;
  logic [31:0]             el_r;
  logic [2:0]              ty_r;
  logic [DUR_W-1:0]        dur_r;
  logic [7:0]              cyc_r;
  logic [NPW-1:0]          np_r;
  logic                    done_r;
  logic                    inf_r;
  logic                    tmr_r;
  logic [P_W-1:0]          p_r;
  logic [PIW-1:0]          k_r;
  logic [15:0]             t_r;
  logic [31:0]             va_r;
  logic [31:0]             vb_r;
  logic signed [SUM_W-1:0] prod_a_r;
  logic [P_W-1:0]          pm_r;
  logic                    pneg_r;
  logic [TERM_W-1:0]       term_r;
  out_word_t               res_r;
  logic                    fin_r;
  logic [SW-1:0]           cslot_r;
  logic [NPW-1:0]          cnp_r;
  logic [NPW-1:0]          ci_r;
  logic                    out_valid_r;
  out_word_t               out_data_r;

  logic [SW-1:0]      cur;
  logic               out_free;
  logic               free_any;
  logic [SW-1:0]      free_idx;
  logic               match_any;
  logic [SW-1:0]      match_idx;
  logic [NPW-1:0]     np_in;
  logic [31:0]        el_c;
  logic               inf_c;
  logic               done_c;
  logic [P_W-1:0]     p_sh;
  logic [32:0]        dm;
  logic [TERM_W-1:0]  t_sum;
  logic [SUM_W-1:0]   pa_mag;
  logic signed [SUM_W-1:0] sb;
  logic signed [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0]   sum_mag;
  logic signed [42:0] r_c;
  logic [31:0]        val_c;
  logic               emit_c;
  logic [PIW-1:0]     k_c;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic [PIW-1:0]     pidx;

  assign cur      = s_r[SW-1:0];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pidx     = PIW'(in_data.point_index);

  always_comb begin
    free_any  = 1'b0;
    free_idx  = '0;
    match_any = 1'b0;
    match_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
      if (valid_r[i] && slot_id_r[i] == in_data.anim_id) begin
        match_any = 1'b1;
        match_idx = SW'(i);
      end
    end
  end

  always_comb begin
    if (in_data.point_count < 5'd2) begin
      np_in = NPW'(2);
    end else if (32'(in_data.point_count) > MAX_POINTS) begin
      np_in = NPW'(MAX_POINTS);
    end else begin
      np_in = NPW'(in_data.point_count);
    end
  end

  always_comb begin
    el_c   = now_r - slot_time_r[cur];
    inf_c  = (slot_ty_r[cur] == TY_INFINITE) || (slot_ty_r[cur] == TY_INF_BOUNCE) ||
             (slot_ty_r[cur] == TY_INF_TIMER);
    done_c = (slot_dur_r[cur] == '0) || ((el_c >= 32'(slot_dur_r[cur])) && !inf_c);
  end

  // progress shaping: wrap, bounce
  always_comb begin
    p_sh = p_r;
    if (!inf_r && p_sh > ONE) begin
      p_sh = p_sh & FMASK;
    end
    if (ty_r == TY_INF_BOUNCE) begin
      p_sh = p_sh & FMASK;
    end
    if (ty_r == TY_BOUNCE || ty_r == TY_INF_BOUNCE) begin
      p_sh = (p_sh <= (ONE >> 1)) ? (p_sh << 1) : ((ONE - p_sh) << 1);
    end
  end

  always_comb begin
    if (int'(mul_p[21:16]) > int'(np_r) - 2) begin
      k_c = PIW'(np_r - NPW'(2));
    end else begin
      k_c = PIW'(mul_p[21:16]);
    end
  end

  always_comb begin
    dm      = mag33(slot_delta_r[cur]);
    t_sum   = term_r + TERM_W'(mul_p[PROD_W-1:16]);
    pa_mag  = mul_p[SUM_W-1:0];
    sb      = vb_r[31] ? -$signed(pa_mag) : $signed(pa_mag);
    sum_c   = prod_a_r + sb;
    sum_mag = sum_c[SUM_W-1] ? (SUM_W'(0) - sum_c) : sum_c;
    r_c     = 43'(slot_sv_r[cur]) +
              (((pneg_r ^ slot_delta_r[cur][32]) ? -$signed({2'b0, term_r})
                                                 : $signed({2'b0, term_r})));
    if (r_c[42:31] == '0 || r_c[42:31] == '1) begin
      val_c = r_c[31:0];
    end else if (r_c[42]) begin
      val_c = 32'h8000_0000;
    end else begin
      val_c = 32'h7fff_ffff;
    end
    emit_c = !tmr_r || done_r || (p_r >= ONE);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_CE_MUL: begin
        mul_a = MUL_W'(cyc_r);
        mul_b = MUL_W'(el_r);
      end
      S_K_MUL: begin
        mul_a = MUL_W'(p_r[15:0]);
        mul_b = MUL_W'(np_r) - MUL_W'(1);
      end
      S_K_MA: begin
        mul_a = MUL_W'(ONE) - MUL_W'(t_r);
        mul_b = mag32(va_r);
      end
      S_K_MB: begin
        mul_a = MUL_W'(t_r);
        mul_b = mag32(vb_r);
      end
      S_BL0: begin
        mul_a = MUL_W'(pm_r[47:16]);
        mul_b = dm;
      end
      S_BL1: begin
        mul_a = MUL_W'(pm_r[15:0]);
        mul_b = dm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_KF_LAST: rd_addr = AW'(int'(cur) * MAX_POINTS + int'(np_r) - 1);
      S_K_RB:    rd_addr = AW'(int'(cur) * MAX_POINTS + int'(k_r) + 1);
      default:   rd_addr = AW'(int'(cur) * MAX_POINTS + int'(k_r));
    endcase
    wr_addr = AW'(int'(cslot_r) * MAX_POINTS + int'(ci_r));
  end

  assign div_start = (state_r == S_DIV_GO);

  att_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  att_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mul_p[39:0], FRAC_BITS'(0)}),
    .divisor  (dur_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_COPY) begin
      kf_ram_r[wr_addr] <= staged_r[ci_r[PIW-1:0]];
    end
    rd_data_r <= kf_ram_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.cmd)
              CMD_ADD: begin
                fin_r <= 1'b1;
                if (free_any) begin
                  valid_r[free_idx]      <= 1'b1;
                  slot_id_r[free_idx]    <= next_id_r;
                  slot_time_r[free_idx]  <= in_data.now_ms;
                  slot_sv_r[free_idx]    <= in_data.start_val;
                  slot_delta_r[free_idx] <= {in_data.end_val[31], in_data.end_val} -
                                            {in_data.start_val[31], in_data.start_val};
                  slot_dur_r[free_idx]   <= in_data.duration_ms;
                  slot_cyc_r[free_idx]   <= in_data.cycle_count;
                  slot_ty_r[free_idx]    <= in_data.anim_type;
                  slot_np_r[free_idx]    <= np_in;
                  cslot_r                <= free_idx;
                  cnp_r                  <= np_in;
                  ci_r                   <= '0;
                  res_r     <= '{kind: KIND_ADD_ACK, result_id: next_id_r, frame_value: '0,
                                 complete: 1'b0, found: 1'b1, last: 1'b1};
                  next_id_r <= next_id_r + 32'd1;
                  state_r   <= S_COPY;
                end else begin
                  res_r   <= '{kind: KIND_ADD_ACK, result_id: '0, frame_value: '0,
                               complete: 1'b0, found: 1'b0, last: 1'b1};
                  state_r <= S_OUT;
                end
              end
              CMD_REMOVE: begin
                if (match_any) begin
                  valid_r[match_idx] <= 1'b0;
                end
                fin_r   <= 1'b1;
                res_r   <= '{kind: KIND_REM_ACK, result_id: in_data.anim_id, frame_value: '0,
                             complete: 1'b0, found: match_any, last: 1'b1};
                state_r <= S_OUT;
              end
              CMD_TICK: begin
                now_r   <= in_data.now_ms;
                s_r     <= '0;
                state_r <= S_SCAN;
              end
              CMD_LOAD: begin
                if (32'(in_data.point_index) < MAX_POINTS) begin
                  staged_r[pidx] <= in_data.point_value;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_COPY: begin
          ci_r <= ci_r + NPW'(1);
          if (ci_r == cnp_r - NPW'(1)) begin
            state_r <= S_OUT;
          end
        end
        S_SCAN: begin
          if (32'(s_r) == SLOTS) begin
            fin_r   <= 1'b1;
            res_r   <= '{kind: KIND_EOT, result_id: '0, frame_value: '0,
                         complete: 1'b0, found: 1'b0, last: 1'b1};
            state_r <= S_OUT;
          end else if (!valid_r[cur]) begin
            s_r <= s_r + CW'(1);
          end else begin
            el_r   <= el_c;
            ty_r   <= slot_ty_r[cur];
            dur_r  <= slot_dur_r[cur];
            cyc_r  <= slot_cyc_r[cur];
            np_r   <= slot_np_r[cur];
            inf_r  <= inf_c;
            tmr_r  <= (slot_ty_r[cur] == TY_TIMER) || (slot_ty_r[cur] == TY_INF_TIMER);
            done_r <= done_c;
            if (done_c) begin
              p_r     <= ONE;
              state_r <= S_SHAPE;
            end else begin
              state_r <= S_CE_MUL;
            end
          end
        end
        S_CE_MUL:   state_r <= S_DIV_GO;
        S_DIV_GO:   state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            p_r     <= P_W'(div_q);
            state_r <= S_SHAPE;
          end
        end
        S_SHAPE: begin
          p_r <= p_sh;
          if (ty_r == TY_PARAM) begin
            state_r <= (done_r || p_sh >= ONE) ? S_KF_LAST : S_K_MUL;
          end else begin
            pm_r    <= p_sh;
            pneg_r  <= 1'b0;
            state_r <= S_BL0;
          end
        end
        S_KF_LAST: state_r <= S_KF_DATA;
        S_KF_DATA: begin
          pm_r    <= P_W'(mag32(rd_data_r));
          pneg_r  <= rd_data_r[31];
          state_r <= S_BL0;
        end
        S_K_MUL: state_r <= S_K_IDX;
        S_K_IDX: begin
          k_r     <= k_c;
          t_r     <= mul_p[15:0];
          state_r <= S_K_RA;
        end
        S_K_RA: state_r <= S_K_RB;
        S_K_RB: begin
          va_r    <= rd_data_r;
          state_r <= S_K_MA;
        end
        S_K_MA: begin
          vb_r    <= rd_data_r;
          state_r <= S_K_MB;
        end
        S_K_MB: begin
          prod_a_r <= va_r[31] ? -$signed(pa_mag) : $signed(pa_mag);
          state_r  <= S_K_SUM;
        end
        S_K_SUM: begin
          pm_r    <= P_W'(sum_mag >> 16);
          pneg_r  <= sum_c[SUM_W-1];
          state_r <= S_BL0;
        end
        S_BL0: begin
          if (dm == '0 || pm_r == '0) begin
            term_r  <= '0;
            state_r <= S_BL3;
          end else if (|pm_r[P_W-1:48]) begin
            term_r  <= TERM_LIM;
            state_r <= S_BL3;
          end else begin
            state_r <= S_BL1;
          end
        end
        S_BL1: begin
          term_r  <= (mul_p > PROD_W'(TERM_LIM)) ? TERM_LIM : mul_p[TERM_W-1:0];
          state_r <= S_BL2;
        end
        S_BL2: begin
          term_r  <= (t_sum > TERM_LIM) ? TERM_LIM : t_sum;
          state_r <= S_BL3;
        end
        S_BL3: begin
          if (emit_c) begin
            fin_r   <= 1'b0;
            res_r   <= '{kind: KIND_FRAME, result_id: slot_id_r[cur], frame_value: val_c,
                         complete: done_r, found: 1'b0, last: 1'b0};
            state_r <= S_OUT;
            if (done_r) begin
              valid_r[cur] <= 1'b0;
            end else if (ty_r == TY_INF_TIMER) begin
              slot_time_r[cur] <= now_r;
            end
          end else begin
            s_r     <= s_r + CW'(1);
            state_r <= S_SCAN;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            if (fin_r) begin
              state_r <= S_IDLE;
            end else begin
              s_r     <= s_r + CW'(1);
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_TICK) |=> in_stall)
    else $error("tick accepted without going busy");

  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_EOT) |-> (out_data.last && !out_data.complete))
    else $error("end of tick word malformed");

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == KIND_ADD_ACK || out_data.kind == KIND_REM_ACK)) |->
    (!out_data.complete && out_data.frame_value == 0 && out_data.last))
    else $error("ack word carries frame fields");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ===== tb/tb_animation_tween_table.sv =====
`timescale 1ns / 1ps
module tb_animation_tween_table;
  import att_pkg::*;

  localparam logic [2:0] TY_NONE   = 3'd0;
  localparam logic [2:0] TY_LINEAR = 3'd1;
  localparam int NSLOT = 16;
  localparam int NPTS  = 16;
  localparam int LIMIT = 5000000;
  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
  localparam longint unsigned FRAC = UNIT - 1;
  localparam longint unsigned CAP  = 64'd1 << 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  logic      typed_flag;
  out_word_t typed_word;

  animation_tween_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  bit               live[NSLOT];
  logic [31:0]      anim_ids[NSLOT];
  logic [31:0]      t0[NSLOT];
  longint           v0[NSLOT];
  longint           dv[NSLOT];
  logic [23:0]      dur[NSLOT];
  logic [7:0]       cyc[NSLOT];
  logic [2:0]       ty[NSLOT];
  int               npts[NSLOT];
  longint           keys[NSLOT][NPTS];
  longint           staged[NPTS];
  logic [31:0]      id_next;
  bit [NPTS-1:0]    loaded;

  out_word_t expected_words[$];
  int errors;
  int cycles;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] blend_value(longint start, longint param, longint delta);
    longint unsigned pm, dm, ip, fp, term;
    bit neg;
    longint r;
    neg = (param < 0) != (delta < 0);
    pm = param < 0 ? -param : param;
    dm = delta < 0 ? -delta : delta;
    ip = pm >> FRAC_BITS;
    fp = pm & FRAC;
    if (dm == 0 || pm == 0) term = 0;
    else if (ip >= (64'd1 << 32)) term = CAP;
    else begin
      term = ip * dm;
      if (term > CAP) term = CAP;
      term += (fp * dm) >> FRAC_BITS;
      if (term > CAP) term = CAP;
    end
    r = start + (neg ? -longint'(term) : longint'(term));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic out_word_t word_of(logic [1:0] k, logic [31:0] id, logic [31:0] v,
                                        bit c, bit f, bit l);
    out_word_t o;
    o.kind = k; o.result_id = id; o.frame_value = v;
    o.complete = c; o.found = f; o.last = l;
    return o;
  endfunction

  task automatic queue_exp(out_word_t o);
    expected_words.insert(expected_words.size(), o);
  endtask

  function automatic int clamp_points(logic [4:0] n);
    if (n < 2) return 2;
    if (n > NPTS) return NPTS;
    return n;
  endfunction

  task automatic tick_slots(logic [31:0] now);
    bit inf, tmr, done;
    logic [31:0] el, v;
    longint unsigned p, x, t, m;
    longint sum, q;
    int k, np;
    for (int s = 0; s < NSLOT; s++) begin
      if (!live[s]) continue;
      inf = ty[s] == TY_INFINITE || ty[s] == TY_INF_BOUNCE || ty[s] == TY_INF_TIMER;
      tmr = ty[s] == TY_TIMER || ty[s] == TY_INF_TIMER;
      el = now - t0[s];
      done = dur[s] == 0 || (el >= dur[s] && !inf);
      if (done) p = UNIT;
      else p = ((longint'(cyc[s]) * longint'(el)) << FRAC_BITS) / longint'(dur[s]);
      if (!inf && p > UNIT) p &= FRAC;
      if (ty[s] == TY_INF_BOUNCE) p &= FRAC;
      if (ty[s] == TY_BOUNCE || ty[s] == TY_INF_BOUNCE)
        p = 2 * (p <= UNIT / 2 ? p : UNIT - p);
      if (ty[s] == TY_PARAM) begin
        np = npts[s];
        if (done || p >= UNIT) v = blend_value(v0[s], keys[s][np-1], dv[s]);
        else begin
          x = p * (np - 1);
          k = int'(x >> FRAC_BITS);
          t = x & FRAC;
          if (k > np - 2) k = np - 2;
          sum = longint'(UNIT - t) * keys[s][k] + longint'(t) * keys[s][k+1];
          m = (sum < 0 ? -sum : sum) >> 16;
          q = sum < 0 ? -longint'(m) : longint'(m);
          v = blend_value(v0[s], q, dv[s]);
        end
      end else begin
        if (p >= (64'd1 << 62)) p = 64'd1 << 62;
        v = blend_value(v0[s], longint'(p), dv[s]);
      end
      if (!tmr || done || p >= UNIT) begin
        queue_exp(word_of(KIND_FRAME, anim_ids[s], v, done, 0, 0));
        if (done) live[s] = 0;
        else if (ty[s] == TY_INF_TIMER) t0[s] = now;
      end
    end
    queue_exp(word_of(KIND_EOT, 0, 0, 0, 0, 1));
  endtask

  task automatic tween_predict(in_word_t w);
    int s;
    bit f;
    case (w.cmd)
      CMD_ADD: begin
        for (s = 0; s < NSLOT; s++) if (!live[s]) break;
        if (s >= NSLOT) queue_exp(word_of(KIND_ADD_ACK, 0, 0, 0, 0, 1));
        else begin
          live[s] = 1;
          anim_ids[s] = id_next;
          t0[s] = w.now_ms;
          v0[s] = longint'(w.start_val);
          dv[s] = longint'(w.end_val) - longint'(w.start_val);
          dur[s] = w.duration_ms;
          cyc[s] = w.cycle_count;
          ty[s] = w.anim_type;
          npts[s] = clamp_points(w.point_count);
          for (int i = 0; i < npts[s]; i++) keys[s][i] = staged[i];
          queue_exp(word_of(KIND_ADD_ACK, id_next, 0, 0, 1, 1));
          id_next++;
        end
      end
      CMD_REMOVE: begin
        f = 0;
        for (s = 0; s < NSLOT; s++)
          if (live[s] && anim_ids[s] == w.anim_id) begin
            live[s] = 0;
            f = 1;
            break;
          end
        queue_exp(word_of(KIND_REM_ACK, w.anim_id, 0, 0, f, 1));
      end
      CMD_TICK: tick_slots(w.now_ms);
      CMD_LOAD: begin
        staged[w.point_index] = longint'(w.point_value);
        loaded[w.point_index] = 1;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      tween_predict(in_data);
      if (typed_flag) begin
        expected_words[expected_words.size() - 1] = typed_word;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_data);
      end else begin
        e = expected_words.pop_front();
        if (out_data.kind !== e.kind || out_data.result_id !== e.result_id ||
            out_data.frame_value !== e.frame_value || out_data.complete !== e.complete ||
            out_data.found !== e.found || out_data.last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k%0d id%h v%h c%0d f%0d l%0d got k%0d id%h v%h c%0d f%0d l%0d",
                     e.kind, e.result_id, e.frame_value, e.complete, e.found, e.last,
                     out_data.kind, out_data.result_id, out_data.frame_value,
                     out_data.complete, out_data.found, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls, mostly short
  initial begin
    int n;
    out_stall = 0;
    forever begin
      n = $urandom_range(0, 30);
      repeat (n) @(posedge clk);
      out_stall <= 1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (n) @(posedge clk);
      out_stall <= 0;
    end
  end

  task automatic send_word(in_word_t w, bit typed, out_word_t tw);
    int gap;
    in_valid <= 1;
    in_data <= w;
    typed_flag <= typed;
    typed_word <= tw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 2) != 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t noise_word(logic [1:0] c);
    logic [223:0] raw;
    in_word_t w;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.cmd = c;
    return w;
  endfunction

  function automatic row_t mk(logic [1:0] c, logic [31:0] a, logic [31:0] sv, logic [31:0] ev,
                              logic [23:0] d, logic [7:0] cc, logic [2:0] at,
                              logic [3:0] pi, logic [31:0] pv, logic [4:0] pc,
                              logic [31:0] now);
    row_t r;
    r.w.cmd = c; r.w.anim_id = a; r.w.start_val = sv; r.w.end_val = ev;
    r.w.duration_ms = d; r.w.cycle_count = cc; r.w.anim_type = at;
    r.w.point_index = pi; r.w.point_value = pv; r.w.point_count = pc; r.w.now_ms = now;
    r.typed = 0;
    r.exp = '0;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, out_word_t e);
    r.typed = 1;
    r.exp = e;
    return r;
  endfunction

  task automatic add_row(row_t r);
    rows.insert(rows.size(), r);
  endtask

  initial begin
    in_word_t w;
    logic [31:0] now;
    int pick, np;
    errors = 0;
    cycles = 0;
    for (int s = 0; s < NSLOT; s++) live[s] = 0;
    id_next = 1;
    loaded = '0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    typed_flag = 0;
    typed_word = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 1, 0, 0, 32'h80000000, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 1, 0, 1, 32'h7fffffff, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 1, 0, 2, 32'h00010000, 0, 0));
    add_row(mk(CMD_LOAD, 0, 0, 0, 0, 1, 0, 3, 32'h00000000, 0, 0));
    add_row(typed_row(mk(CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0),
                      word_of(KIND_EOT, 0, 0, 0, 0, 1)));
    add_row(typed_row(mk(CMD_REMOVE, 5, 0, 0, 0, 1, 0, 0, 0, 0, 0),
                      word_of(KIND_REM_ACK, 5, 0, 0, 0, 1)));
    add_row(typed_row(mk(CMD_ADD, 0, 32'h80000000, 32'h7fffffff, 1000, 1, TY_LINEAR,
                         0, 0, 2, 0), word_of(KIND_ADD_ACK, 1, 0, 0, 1, 1)));
    add_row(typed_row(mk(CMD_ADD, 0, 32'h10000, 32'h20000, 0, 1, TY_INFINITE,
                         0, 0, 2, 0), word_of(KIND_ADD_ACK, 2, 0, 0, 1, 1)));
    add_row(mk(CMD_ADD, 0, 0, 32'h00640000, 100, 2, TY_BOUNCE, 0, 0, 2, 0));
    add_row(mk(CMD_ADD, 0, 0, 32'h7fff0000, 1, 255, TY_INFINITE, 0, 0, 2, 0));
    add_row(mk(CMD_ADD, 0, 32'hfff00000, 32'h00100000, 300, 3, TY_INF_BOUNCE,
               0, 0, 2, 0));
    add_row(mk(CMD_ADD, 0, 0, 32'h00010000, 50, 1, TY_TIMER, 0, 0, 2, 0));
    add_row(mk(CMD_ADD, 0, 0, 32'h00010000, 40, 1, TY_INF_TIMER, 0, 0, 2, 0));
    add_row(mk(CMD_ADD, 0, 32'h00010000, 32'h00030000, 200, 1, TY_PARAM, 0, 0, 0, 0));
    add_row(mk(CMD_ADD, 0, 32'h7fffffff, 32'h80000000, 100, 4, TY_PARAM, 0, 0, 4, 0));
    add_row(mk(CMD_ADD, 0, 0, 32'h00050000, 24'hffffff, 255, TY_NONE, 4'hf,
               32'hffffffff, 5'h1f, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 25));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 60));
    add_row(typed_row(mk(CMD_REMOVE, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0),
                      word_of(KIND_REM_ACK, 1, 0, 0, 1, 1)));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 32'hffffffff));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 32'h00000130));

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].exp);
    drain();

    now = 32'h00000200;
    for (int i = 0; i < 220; i++) begin
      if (i == 110) drain();
      if ($urandom_range(0, 19) == 0) now = $urandom;
      else now += $urandom_range(0, 300);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        w = noise_word(CMD_ADD);
        case ($urandom_range(0, 9))
          0: w.duration_ms = 0;
          1, 2: w.duration_ms = 24'($urandom);
          3: w.duration_ms = 24'($urandom_range(1, 20));
          default: w.duration_ms = 24'($urandom_range(1, 2000));
        endcase
        w.cycle_count = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) w.cycle_count = 8'($urandom_range(1, 4));
        w.now_ms = now;
        if (w.anim_type == TY_PARAM) begin
          np = clamp_points(w.point_count);
          for (int k = 0; k < np; k++) if (!loaded[k]) w.anim_type = TY_LINEAR;
        end
      end else if (pick < 65) begin
        w = noise_word(CMD_TICK);
        w.now_ms = now;
      end else if (pick < 80) begin
        w = noise_word(CMD_REMOVE);
        if ($urandom_range(0, 9) < 7) w.anim_id = id_next - $urandom_range(1, 20);
      end else w = noise_word(CMD_LOAD);
      send_word(w, 0, '0);
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
